>>> sv/nnfd_pkg.sv
// ----------------------------------------------------------------------------
// nnfd_pkg
// shared types and constants for the nearest neighbour fit downscaler
// ----------------------------------------------------------------------------
package nnfd_pkg;

   localparam int DIM_W   = 14;
   localparam int COORD_W = 13;
   localparam int PIXEL_W = 32;
   localparam int PROD_W  = 2 * DIM_W;
   localparam int DIVD_W  = PROD_W + 2;
   localparam int DIVS_W  = DIM_W + 1;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_MAX_SIDE   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_FIT_W  = 2'd0,
      OP_FIT_H  = 2'd1,
      OP_STEP_W = 2'd2,
      OP_STEP_H = 2'd3
   } div_op_type;

   typedef struct packed {
      logic       clear;
      logic       mul_en;
      logic       div_start;
      logic       store;
      logic       run;
      div_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic div_done;
   } ctrl_status_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_in;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic [DIM_W-1:0]   out_width;
      logic [DIM_W-1:0]   out_height;
      logic               frame_last;
   } rsp_payload_type;

endpackage

>>> sv/nnfd_stream_if.sv
// ----------------------------------------------------------------------------
// nnfd_stream_if
// valid/ready stream channel carrying one payload struct
// ----------------------------------------------------------------------------
interface nnfd_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/nnfd_divider.sv
// ----------------------------------------------------------------------------
// nnfd_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nnfd_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nnfd_pkg::DIVD_W-1:0] dividend,
   input  logic [nnfd_pkg::DIVS_W-1:0] divisor,
   output logic                        done,
   output logic [nnfd_pkg::DIVD_W-1:0] quotient,
   output logic [nnfd_pkg::DIVS_W-1:0] remainder
);
   localparam int ITER  = nnfd_pkg::DIVD_W;
   localparam int CNT_W = $clog2(ITER);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [nnfd_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [nnfd_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [nnfd_pkg::DIVS_W-1:0] dvs_ff, dvs_in;
   logic [nnfd_pkg::DIVS_W:0]   trial;

   assign trial = {rem_ff, quo_ff[nnfd_pkg::DIVD_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = nnfd_pkg::DIVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[nnfd_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[nnfd_pkg::DIVS_W-1:0];
            quo_in = {quo_ff[nnfd_pkg::DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> sv/nnfd_datapath.sv
// ----------------------------------------------------------------------------
// nnfd_datapath
// config registers, size fitting arithmetic and the pixel selection stream
// ----------------------------------------------------------------------------
module nnfd_datapath #(
   parameter int MAX_DIM = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [nnfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnfd_pkg::DIM_W-1:0]     csr_write_data,
   input  nnfd_pkg::ctrl_cmd_type         cmd,
   output nnfd_pkg::ctrl_status_type      status,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  nnfd_pkg::req_payload_type      req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output nnfd_pkg::rsp_payload_type      rsp_payload
);
   localparam int DW = nnfd_pkg::DIM_W;

   function automatic logic [DW-1:0] clamp_dim(logic [DW-1:0] v);
      logic [DW-1:0] r;
      if (v == '0) begin
         r = DW'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DW'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic [DW-1:0] src_width_ff, src_height_ff, max_side_ff;
   logic [DW-1:0] sw, sh, ms, longest;
   logic          scale;
   logic          csr_hit;

   logic [nnfd_pkg::PROD_W-1:0] prod_ff;
   logic [DW-1:0]               mul_a;

   logic [nnfd_pkg::DIVD_W-1:0] div_dividend, div_quo;
   logic [nnfd_pkg::DIVS_W-1:0] div_divisor, div_rem;
   logic                        div_done;
   logic [DW-1:0]               fit_val;

   logic [DW-1:0] fit_w_ff, fit_h_ff;
   logic [DW-1:0] col_qstep_ff, col_rstep_ff, row_qstep_ff, row_rstep_ff;

   logic [DW-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [DW-1:0] dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [DW-1:0] col_quo_ff, col_quo_in, col_rem_ff, col_rem_in;
   logic [DW-1:0] row_quo_ff, row_quo_in, row_rem_ff, row_rem_in;

   logic          accept, row_hit, col_hit, hit, col_end, row_end;
   logic [DW:0]   col_rsum, row_rsum;
   logic          col_wrap, row_wrap;

   logic                      rsp_valid_ff;
   nnfd_pkg::rsp_payload_type rsp_payload_ff;

   assign csr_hit = csr_write_en &&
                    (csr_index == nnfd_pkg::CSR_SRC_WIDTH ||
                     csr_index == nnfd_pkg::CSR_SRC_HEIGHT ||
                     csr_index == nnfd_pkg::CSR_MAX_SIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DW'(1);
         src_height_ff <= DW'(1);
         max_side_ff   <= DW'(128);
      end else if (csr_write_en) begin
         case (csr_index)
            nnfd_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_write_data;
            nnfd_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_write_data;
            nnfd_pkg::CSR_MAX_SIDE:   max_side_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign sw      = clamp_dim(src_width_ff);
   assign sh      = clamp_dim(src_height_ff);
   assign ms      = clamp_dim(max_side_ff);
   assign longest = (sw > sh) ? sw : sh;
   assign scale   = (sw > ms) || (sh > ms);

   // size fitting: product, then shared divider
   assign mul_a = (cmd.op == nnfd_pkg::OP_FIT_W) ? sw : sh;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= nnfd_pkg::PROD_W'(mul_a) * nnfd_pkg::PROD_W'(ms);
      end
   end

   always_comb begin
      case (cmd.op)
         nnfd_pkg::OP_FIT_W, nnfd_pkg::OP_FIT_H: begin
            div_dividend = {1'b0, prod_ff, 1'b0} + nnfd_pkg::DIVD_W'(longest);
            div_divisor  = {longest, 1'b0};
         end
         nnfd_pkg::OP_STEP_W: begin
            div_dividend = nnfd_pkg::DIVD_W'(sw);
            div_divisor  = {1'b0, fit_w_ff};
         end
         nnfd_pkg::OP_STEP_H: begin
            div_dividend = nnfd_pkg::DIVD_W'(sh);
            div_divisor  = {1'b0, fit_h_ff};
         end
         default: begin
            div_dividend = '0;
            div_divisor  = nnfd_pkg::DIVS_W'(1);
         end
      endcase
   end

   nnfd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign fit_val = (div_quo == '0) ? DW'(1) : div_quo[DW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_w_ff <= DW'(1);
         fit_h_ff <= DW'(1);
      end else if (cmd.store) begin
         case (cmd.op)
            nnfd_pkg::OP_FIT_W: fit_w_ff <= scale ? fit_val : sw;
            nnfd_pkg::OP_FIT_H: fit_h_ff <= scale ? fit_val : sh;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.op)
            nnfd_pkg::OP_STEP_W: begin
               col_qstep_ff <= div_quo[DW-1:0];
               col_rstep_ff <= div_rem[DW-1:0];
            end
            nnfd_pkg::OP_STEP_H: begin
               row_qstep_ff <= div_quo[DW-1:0];
               row_rstep_ff <= div_rem[DW-1:0];
            end
            default: ;
         endcase
      end
   end

   assign status.cfg_write = csr_hit;
   assign status.div_done  = div_done;

   // pixel stream
   assign req_ready = cmd.run && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign row_hit = (dst_row_ff < fit_h_ff) && (src_row_ff == row_quo_ff);
   assign col_hit = (dst_col_ff < fit_w_ff) && (src_col_ff == col_quo_ff);
   assign hit     = row_hit && col_hit;

   assign col_end = ({1'b0, src_col_ff} + (DW+1)'(1)) >= {1'b0, sw};
   assign row_end = ({1'b0, src_row_ff} + (DW+1)'(1)) >= {1'b0, sh};

   assign col_rsum = {1'b0, col_rem_ff} + {1'b0, col_rstep_ff};
   assign row_rsum = {1'b0, row_rem_ff} + {1'b0, row_rstep_ff};
   assign col_wrap = col_rsum >= {1'b0, fit_w_ff};
   assign row_wrap = row_rsum >= {1'b0, fit_h_ff};

   always_comb begin
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      dst_col_in = dst_col_ff;
      dst_row_in = dst_row_ff;
      col_quo_in = col_quo_ff;
      col_rem_in = col_rem_ff;
      row_quo_in = row_quo_ff;
      row_rem_in = row_rem_ff;
      if (cmd.clear) begin
         src_col_in = '0;
         src_row_in = '0;
         dst_col_in = '0;
         dst_row_in = '0;
         col_quo_in = '0;
         col_rem_in = '0;
         row_quo_in = '0;
         row_rem_in = '0;
      end else if (accept) begin
         if (hit) begin
            dst_col_in = dst_col_ff + DW'(1);
            col_rem_in = col_wrap ? DW'(col_rsum - {1'b0, fit_w_ff}) : col_rsum[DW-1:0];
            col_quo_in = col_quo_ff + col_qstep_ff + DW'(col_wrap);
         end
         src_col_in = src_col_ff + DW'(1);
         if (col_end) begin
            src_col_in = '0;
            dst_col_in = '0;
            col_quo_in = '0;
            col_rem_in = '0;
            if (row_hit) begin
               dst_row_in = dst_row_ff + DW'(1);
               row_rem_in = row_wrap ? DW'(row_rsum - {1'b0, fit_h_ff})
                                     : row_rsum[DW-1:0];
               row_quo_in = row_quo_ff + row_qstep_ff + DW'(row_wrap);
            end
            src_row_in = src_row_ff + DW'(1);
            if (row_end) begin
               src_row_in = '0;
               dst_row_in = '0;
               row_quo_in = '0;
               row_rem_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff <= '0;
         src_row_ff <= '0;
         dst_col_ff <= '0;
         dst_row_ff <= '0;
         col_quo_ff <= '0;
         col_rem_ff <= '0;
         row_quo_ff <= '0;
         row_rem_ff <= '0;
      end else begin
         src_col_ff <= src_col_in;
         src_row_ff <= src_row_in;
         dst_col_ff <= dst_col_in;
         dst_row_ff <= dst_row_in;
         col_quo_ff <= col_quo_in;
         col_rem_ff <= col_rem_in;
         row_quo_ff <= row_quo_in;
         row_rem_ff <= row_rem_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= hit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hit) begin
         rsp_payload_ff.pixel_out  <= req_payload.pixel_in;
         rsp_payload_ff.out_x      <= dst_col_ff[nnfd_pkg::COORD_W-1:0];
         rsp_payload_ff.out_y      <= dst_row_ff[nnfd_pkg::COORD_W-1:0];
         rsp_payload_ff.out_width  <= fit_w_ff;
         rsp_payload_ff.out_height <= fit_h_ff;
         rsp_payload_ff.frame_last <= (dst_col_ff == fit_w_ff - DW'(1)) &&
                                      (dst_row_ff == fit_h_ff - DW'(1));
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
endmodule

>>> sv/nnfd_ctrl.sv
// ----------------------------------------------------------------------------
// nnfd_ctrl
// sequencer for size fitting after reset or config write, then streaming
// ----------------------------------------------------------------------------
module nnfd_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  nnfd_pkg::ctrl_status_type status,
   output nnfd_pkg::ctrl_cmd_type    cmd
);
   typedef enum logic [1:0] {
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RUN
   } state_type;

   state_type            state_ff;
   nnfd_pkg::div_op_type op_ff;

   always_ff @(posedge clock) begin
      if (reset || status.cfg_write) begin
         state_ff <= ST_MUL;
         op_ff    <= nnfd_pkg::OP_FIT_W;
      end else begin
         case (state_ff)
            ST_MUL:       state_ff <= ST_DIV_START;
            ST_DIV_START: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (status.div_done) begin
                  case (op_ff)
                     nnfd_pkg::OP_FIT_W: begin
                        op_ff    <= nnfd_pkg::OP_FIT_H;
                        state_ff <= ST_MUL;
                     end
                     nnfd_pkg::OP_FIT_H: begin
                        op_ff    <= nnfd_pkg::OP_STEP_W;
                        state_ff <= ST_DIV_START;
                     end
                     nnfd_pkg::OP_STEP_W: begin
                        op_ff    <= nnfd_pkg::OP_STEP_H;
                        state_ff <= ST_DIV_START;
                     end
                     default: state_ff <= ST_RUN;
                  endcase
               end
            end
            ST_RUN:  state_ff <= ST_RUN;
            default: state_ff <= ST_MUL;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.op        = op_ff;
      cmd.clear     = (state_ff != ST_RUN);
      cmd.mul_en    = (state_ff == ST_MUL);
      cmd.div_start = (state_ff == ST_DIV_START);
      cmd.store     = (state_ff == ST_DIV_WAIT) && status.div_done;
      cmd.run       = (state_ff == ST_RUN);
   end
endmodule

>>> sv/nearest_neighbor_fit_downscaler_core.sv
// a kept pixel's response appears in the cycle after its request is accepted
// throughput: one request per cycle while running, unless a response stalls
// after reset or a register write the fitted size is recomputed by a shared
// 30-step restoring divider in four divisions, with ready low
// reset is synchronous, active high, and restores the register defaults
// ----------------------------------------------------------------------------
// nearest_neighbor_fit_downscaler_core
// nearest neighbour downscaler fitting the frame into a maximum side
// ----------------------------------------------------------------------------
module nearest_neighbor_fit_downscaler_core #(
   parameter int MAX_DIM = 8192
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [nnfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnfd_pkg::DIM_W-1:0]     csr_write_data,
   nnfd_stream_if.sink                    req_chan,
   nnfd_stream_if.source                  rsp_chan
);
   nnfd_pkg::ctrl_cmd_type    cmd;
   nnfd_pkg::ctrl_status_type status;

   nnfd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   nnfd_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_payload    (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_payload    (rsp_chan.payload)
   );
endmodule

>>> sv/nnfd_checker.sv
// ----------------------------------------------------------------------------
// nnfd_checker
// port level checks on the downscaler, bound to the top level
// ----------------------------------------------------------------------------
module nnfd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_write_en,
   input logic [nnfd_pkg::CSR_IDX_W-1:0] csr_index,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input nnfd_pkg::rsp_payload_type      rsp_payload
);
   logic csr_hit;

   assign csr_hit = csr_write_en &&
                    (csr_index == nnfd_pkg::CSR_SRC_WIDTH ||
                     csr_index == nnfd_pkg::CSR_SRC_HEIGHT ||
                     csr_index == nnfd_pkg::CSR_MAX_SIDE);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_refit_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> !req_ready)
      else $error("request taken while size is refitted");

   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (14'(rsp_payload.out_x) < rsp_payload.out_width) &&
                    (14'(rsp_payload.out_y) < rsp_payload.out_height))
      else $error("output coordinate outside fitted frame");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_last |->
         (14'(rsp_payload.out_x) == rsp_payload.out_width - 14'd1) &&
         (14'(rsp_payload.out_y) == rsp_payload.out_height - 14'd1))
      else $error("frame end flagged away from last pixel");
endmodule

bind nearest_neighbor_fit_downscaler_core nnfd_checker u_nnfd_checker (
   .clock        (clock),
   .reset        (reset),
   .csr_write_en (csr_write_en),
   .csr_index    (csr_index),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_payload  (rsp_chan.payload)
);
